// File: rtl/lzwd_pkg.sv
// Shared constants and types for the LZ window decompressor.
`timescale 1ns / 1ps

package lzwd_pkg;

  // History window geometry
  localparam int WIN_LOG   = 14;
  localparam int WIN_SIZE  = 1 << WIN_LOG;
  localparam int MAX_MATCH = 34;
  localparam int LEN_W     = $clog2(MAX_MATCH + 1);
  localparam int CODE_W    = 16;

  typedef logic [WIN_LOG-1:0] addr_t;  // window address
  typedef logic [WIN_LOG:0]   cnt_t;   // history count or match distance
  typedef logic [LEN_W-1:0]   len_t;   // match length

  // Parser phases
  typedef enum logic [1:0] {
    PH_FLAG,   // collecting the four flag word bytes
    PH_TOKEN,  // expecting a literal or the first byte of a match code
    PH_CODE,   // expecting the second byte of a match code
    PH_COPY    // copying a match out of the window
  } phase_t;

  // One output beat held in the output queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } beat_t;

endpackage

// File: rtl/lzwd_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps

module lzwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lz_window_decompressor_core.sv
// LZSS decompressor with a 16K history window: flag parser, match copier and output queue.
`timescale 1ns / 1ps

// Compressed bytes (stream header removed) enter on s_axis, decompressed bytes leave on
// m_axis. Flag bytes, literals and match code bytes are taken one per cycle while the
// two-beat output queue has room. A match stops the input after its second code byte
// until its length in bytes has been copied out of the window: the window RAM has one
// read port with a registered read and gives one byte per cycle while the output queue
// has room. Back-references into the byte just written are forwarded around the RAM.
// The RAM needs no clearing after reset; bytes beyond the history of the current stream
// read as zero. tlast on the input ends the stream, and everything but the window restarts.

module lz_window_decompressor_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // in_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tlast    // out_last
);

  import lzwd_pkg::*;

  // Parser state
  phase_t      state, state_next;
  logic [1:0]  fcnt;
  logic [31:0] flag_word;
  logic [4:0]  flag_idx;
  logic [7:0]  tok_hi;

  // Window pointers
  addr_t wp;
  cnt_t  hc;

  // Copy sequencer
  addr_t src;
  cnt_t  dist_q;
  cnt_t  rd_hc;
  len_t  rem;
  logic  end_rst;
  logic  rd_valid;
  logic  rd_last;
  logic  zero_q;
  logic  fwd_q;
  logic [7:0] fwd_data;

  // Output queue
  beat_t      fifo_mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] f_cnt;

  // Combinational signals
  logic              in_acc, pop, push, issue, space, copy_done;
  logic              tok_bit, lit_push;
  logic [4:0]        flag_idx_dec;
  logic [CODE_W-1:0] code, len_raw;
  logic [1:0]        sh;
  logic [4:0]        wid;
  logic [CODE_W:0]   len_full, mask, dist_full;
  len_t              len;
  cnt_t              match_dist;
  logic              wr_en;
  logic [7:0]        wr_data, ram_rdata, copy_byte;

  // Handshakes
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state != PH_COPY) && (f_cnt != 2'd2);
  assign m_axis_tvalid = (f_cnt != 2'd0);
  assign m_axis_tdata  = fifo_mem[rd_ptr].data;
  assign m_axis_tlast  = fifo_mem[rd_ptr].last;
  assign pop           = m_axis_tvalid && m_axis_tready;

  // Token flag and literal
  assign tok_bit      = flag_word[flag_idx];
  assign flag_idx_dec = flag_idx - 5'd1;
  assign lit_push     = in_acc && (state == PH_TOKEN) && !s_axis_tlast && !tok_bit;

  // Match code decode: distance width is WIN_LOG minus the flag word's low bits
  assign code       = {tok_hi, s_axis_tdata};
  assign sh         = flag_word[1:0];
  assign wid        = 5'(WIN_LOG) - {3'b000, sh};
  assign len_raw    = code >> wid;
  assign len_full   = {1'b0, len_raw} + (CODE_W+1)'(3);
  assign len        = (len_full > (CODE_W+1)'(MAX_MATCH)) ? len_t'(MAX_MATCH)
                                                          : len_full[LEN_W-1:0];
  assign mask       = ((CODE_W+1)'(1) << wid) - (CODE_W+1)'(1);
  assign dist_full  = ({1'b0, code} & mask) + (CODE_W+1)'(1);
  assign match_dist = cnt_t'(dist_full);

  // Issue a window read only if the queue can take the beat when it returns
  assign space = (({1'b0, f_cnt} + {2'b00, rd_valid}) - {2'b00, pop}) < 3'd2;
  assign issue = (state == PH_COPY) && (rem != '0) && space;

  // Returned byte: zero past the history, forwarded if written in the read cycle
  assign copy_byte = zero_q ? 8'h00 : (fwd_q ? fwd_data : ram_rdata);
  assign copy_done = rd_valid && rd_last;

  // Window write and queue push share one source
  assign wr_en   = lit_push || rd_valid;
  assign wr_data = rd_valid ? copy_byte : s_axis_tdata;
  assign push    = wr_en;

  lzwd_ram #(
    .WIDTH (8),
    .DEPTH (WIN_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wp),
    .wdata (wr_data),
    .re    (issue),
    .raddr (src),
    .rdata (ram_rdata)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_FLAG;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      PH_FLAG: begin
        if (in_acc && !s_axis_tlast && (fcnt == 2'd3)) begin
          state_next = PH_TOKEN;
        end
      end
      PH_TOKEN: begin
        if (in_acc) begin
          if (s_axis_tlast) begin
            state_next = PH_FLAG;
          end else if (tok_bit) begin
            state_next = PH_CODE;
          end else if (flag_idx_dec <= 5'd1) begin
            state_next = PH_FLAG;
          end
        end
      end
      PH_CODE: begin
        if (in_acc) begin
          state_next = PH_COPY;
        end
      end
      PH_COPY: begin
        if (copy_done) begin
          state_next = (end_rst || (flag_idx <= 5'd1)) ? PH_FLAG : PH_TOKEN;
        end
      end
      default: state_next = PH_FLAG;
    endcase
  end

  // Parser, window pointers and copy sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      fcnt      <= '0;
      flag_word <= '0;
      flag_idx  <= '0;
      tok_hi    <= '0;
      wp        <= '0;
      hc        <= '0;
      rem       <= '0;
      end_rst   <= 1'b0;
      rd_valid  <= 1'b0;
    end else begin
      rd_valid <= issue;

      // one window read per cycle while the output queue has room
      if (issue) begin
        rem      <= rem - len_t'(1);
        src      <= src + addr_t'(1);
        rd_hc    <= (rd_hc == cnt_t'(WIN_SIZE)) ? rd_hc : rd_hc + cnt_t'(1);
        zero_q   <= dist_q > rd_hc;
        rd_last  <= (rem == len_t'(1));
        fwd_q    <= wr_en && (wp == src);
        fwd_data <= wr_data;
      end

      // advance the window on every byte written
      if (wr_en) begin
        wp <= wp + addr_t'(1);
        hc <= (hc == cnt_t'(WIN_SIZE)) ? hc : hc + cnt_t'(1);
      end

      // input beats
      if (in_acc) begin
        case (state)
          PH_FLAG: begin
            flag_word <= {flag_word[23:0], s_axis_tdata};
            fcnt      <= fcnt + 2'd1;
            if (fcnt == 2'd3) begin
              flag_idx <= 5'd31;
            end
          end
          PH_TOKEN: begin
            flag_idx <= flag_idx_dec;
            tok_hi   <= s_axis_tdata;
          end
          PH_CODE: begin
            rem     <= len;
            src     <= wp - match_dist[WIN_LOG-1:0];
            dist_q  <= match_dist;
            rd_hc   <= hc;
            end_rst <= s_axis_tlast;
          end
          default: ;
        endcase

        // stream ends on a flag byte or a dropped token
        if (s_axis_tlast && (state == PH_FLAG || state == PH_TOKEN)) begin
          fcnt      <= '0;
          flag_word <= '0;
          flag_idx  <= '0;
          tok_hi    <= '0;
          wp        <= '0;
          hc        <= '0;
        end
      end

      // stream ends after a match copy
      if (copy_done && end_rst) begin
        fcnt      <= '0;
        flag_word <= '0;
        flag_idx  <= '0;
        tok_hi    <= '0;
        wp        <= '0;
        hc        <= '0;
        end_rst   <= 1'b0;
      end
    end
  end

  // Output queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      f_cnt  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      f_cnt <= (f_cnt + {1'b0, push}) - {1'b0, pop};
    end
  end

  // Output queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= '{data: wr_data, last: (rd_valid ? rd_last : 1'b1)};
    end
  end

endmodule

// File: rtl/lzwd_checker.sv
// Port-level checks for the LZ window decompressor, bound to the top level.
`timescale 1ns / 1ps

module lzwd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       s_axis_tlast,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tlast
);

  import lzwd_pkg::*;

  logic m_beat;
  len_t run_cnt;

  assign m_beat = m_axis_tvalid && m_axis_tready;

  // Output beats since the last tlast
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (m_beat) begin
      run_cnt <= m_axis_tlast ? len_t'(0) : run_cnt + len_t'(1);
    end
  end

  // Nothing is offered straight after reset
  a_idle_after_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output beat changed");

  // No run of output bytes is longer than the longest match
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    (m_beat && (run_cnt == len_t'(MAX_MATCH - 1))) |-> m_axis_tlast)
    else $error("output run exceeds the longest match");

  // A waiting input beat holds until it is taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && !s_axis_tready) |=>
      (s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast)))
    else $error("waiting input beat changed");

endmodule

bind lz_window_decompressor_core lzwd_checker u_lzwd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
